FILE: rtl/core/mi3_pkg.sv
`default_nettype none

package mi3_pkg;

  // Entries of one 3x3 matrix and of its inverse
  localparam int unsigned N_ENTRIES = 9;

  // Adjugate entry i = a[COF_P[i]] * a[COF_Q[i]] - a[COF_R[i]] * a[COF_S[i]]
  localparam int unsigned COF_P [0:8] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned COF_Q [0:8] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned COF_R [0:8] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned COF_S [0:8] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // Determinant by row 0: a[k] times the adjugate entry DET_ADJ[k]
  localparam int unsigned DET_ADJ [0:2] = '{0, 3, 6};

  // Register stages of the front end and the fixed part of a lane
  localparam int unsigned FRONT_STAGES = 5;
  localparam int unsigned LANE_FIXED_STAGES = 4;

endpackage

`default_nettype wire

FILE: rtl/core/matrix_inverse_3x3_top.sv
`default_nettype none

// 3x3 matrix inverse, signed fixed point (default Q16.16), by the adjugate.
// Input channel: in_valid/in_ready with the nine elements a00..a22, row-major.
// Output channel: out_valid/out_ready with b00..b22, singular and saturated.
// A transaction on the input channel yields exactly one output transaction.
// Throughput: one matrix per cycle while the receiver does not stall.
// Nine division lanes, one per inverse entry, each a restoring divider with
// one quotient bit per stage, run side by side; a merge register combines
// their flags. The first of 5 front-end stages loads at the accepting edge,
// then 3 lane set-up stages, WORD_BITS + 1 divider stages, a clip stage
// and the output register follow. The divider depth sets the latency.
// A zero determinant gives all-zero entries with singular set. A quotient
// outside the word range is clipped and sets saturated.
// Reset clears every valid bit; the pipeline then holds no transaction.
// When the receiver stalls, the whole pipeline holds and in_ready drops, so
// no transaction is lost while the output waits.
module matrix_inverse_3x3_top #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [WORD_BITS-1:0] a00,
  input  wire logic signed [WORD_BITS-1:0] a01,
  input  wire logic signed [WORD_BITS-1:0] a02,
  input  wire logic signed [WORD_BITS-1:0] a10,
  input  wire logic signed [WORD_BITS-1:0] a11,
  input  wire logic signed [WORD_BITS-1:0] a12,
  input  wire logic signed [WORD_BITS-1:0] a20,
  input  wire logic signed [WORD_BITS-1:0] a21,
  input  wire logic signed [WORD_BITS-1:0] a22,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [WORD_BITS-1:0]      b00,
  output logic signed [WORD_BITS-1:0]      b01,
  output logic signed [WORD_BITS-1:0]      b02,
  output logic signed [WORD_BITS-1:0]      b10,
  output logic signed [WORD_BITS-1:0]      b11,
  output logic signed [WORD_BITS-1:0]      b12,
  output logic signed [WORD_BITS-1:0]      b20,
  output logic signed [WORD_BITS-1:0]      b21,
  output logic signed [WORD_BITS-1:0]      b22,
  output logic                             singular,
  output logic                             saturated
);

  localparam int W   = WORD_BITS;
  localparam int LAT = mi3_pkg::FRONT_STAGES + mi3_pkg::LANE_FIXED_STAGES + W + 1;
  localparam logic [W-1:0] MAX_WORD = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_WORD = {1'b1, {(W-1){1'b0}}};

  logic                  en;
  logic signed [W-1:0]   a_in    [mi3_pkg::N_ENTRIES];
  logic signed [2*W:0]   adj     [mi3_pkg::N_ENTRIES];
  logic signed [3*W+2:0] det;
  logic [W-1:0]          l_value [mi3_pkg::N_ENTRIES];
  logic [mi3_pkg::N_ENTRIES-1:0] l_sat;
  logic [mi3_pkg::N_ENTRIES-1:0] l_zero;
  logic [LAT-1:0]        vld;
  logic [W-1:0]          b_out   [mi3_pkg::N_ENTRIES];
  logic                  all_zero;
  logic                  any_extreme;

  // Hold every stage while a finished transaction waits at the output
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  assign a_in[0] = a00;
  assign a_in[1] = a01;
  assign a_in[2] = a02;
  assign a_in[3] = a10;
  assign a_in[4] = a11;
  assign a_in[5] = a12;
  assign a_in[6] = a20;
  assign a_in[7] = a21;
  assign a_in[8] = a22;

  mi3_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk (clk),
    .en  (en),
    .a   (a_in),
    .adj (adj),
    .det (det)
  );

  // One division lane per inverse entry
  for (genvar i = 0; i < mi3_pkg::N_ENTRIES; i++) begin : g_lane
    mi3_lane #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .cof   (adj[i]),
      .det   (det),
      .value (l_value[i]),
      .sat   (l_sat[i]),
      .zero  (l_zero[i])
    );
  end

  // Track transactions in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[LAT-2:0], in_valid};
      out_valid <= vld[LAT-1];
    end
  end

  // Merge the lanes: force zeros on a singular matrix, combine clip flags
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < mi3_pkg::N_ENTRIES; i++) begin
        b_out[i] <= l_zero[0] ? '0 : l_value[i];
      end
      singular  <= l_zero[0];
      saturated <= ~l_zero[0] & (|l_sat);
    end
  end

  assign b00 = b_out[0];
  assign b01 = b_out[1];
  assign b02 = b_out[2];
  assign b10 = b_out[3];
  assign b11 = b_out[4];
  assign b12 = b_out[5];
  assign b20 = b_out[6];
  assign b21 = b_out[7];
  assign b22 = b_out[8];

  // Summaries of the output entries for checking
  always_comb begin
    all_zero    = 1'b1;
    any_extreme = 1'b0;
    for (int i = 0; i < mi3_pkg::N_ENTRIES; i++) begin
      all_zero    = all_zero & (b_out[i] == '0);
      any_extreme = any_extreme | (b_out[i] == MAX_WORD) | (b_out[i] == MIN_WORD);
    end
  end

  a_singular_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> !saturated && all_zero)
    else $error("singular result carries nonzero entries or a clip flag");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> any_extreme)
    else $error("clip flag set but no entry sits at a range limit");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result lost while the receiver stalled");

endmodule

`default_nettype wire

FILE: rtl/core/mi3_front.sv
`default_nettype none

module mi3_front #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [WORD_BITS-1:0]    a   [mi3_pkg::N_ENTRIES],
  output logic signed [2*WORD_BITS:0]         adj [mi3_pkg::N_ENTRIES],
  output logic signed [3*WORD_BITS+2:0]       det
);

  localparam int W  = WORD_BITS;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic signed [2*W-1:0] pp   [mi3_pkg::N_ENTRIES];
  logic signed [2*W-1:0] pq   [mi3_pkg::N_ENTRIES];
  logic signed [W-1:0]   row1 [3];
  logic signed [CW-1:0]  cof2 [mi3_pkg::N_ENTRIES];
  logic signed [W-1:0]   row2 [3];
  logic signed [2*W+1:0] plo  [3];
  logic signed [2*W-1:0] phi  [3];
  logic signed [CW-1:0]  cof3 [mi3_pkg::N_ENTRIES];
  logic signed [DW-1:0]  term [3];
  logic signed [CW-1:0]  cof4 [mi3_pkg::N_ENTRIES];

  // Advance all stages together on enable
  always_ff @(posedge clk) begin
    if (en) begin
      // form the two products of each cofactor
      for (int i = 0; i < mi3_pkg::N_ENTRIES; i++) begin
        pp[i] <= a[mi3_pkg::COF_P[i]] * a[mi3_pkg::COF_Q[i]];
        pq[i] <= a[mi3_pkg::COF_R[i]] * a[mi3_pkg::COF_S[i]];
      end
      for (int k = 0; k < 3; k++) begin
        row1[k] <= a[k];
      end

      // subtract to get the exact cofactors
      for (int i = 0; i < mi3_pkg::N_ENTRIES; i++) begin
        cof2[i] <= {pp[i][2*W-1], pp[i]} - {pq[i][2*W-1], pq[i]};
      end
      row2 <= row1;

      // split each determinant product into a low and a high partial
      for (int k = 0; k < 3; k++) begin
        plo[k] <= row2[k] * $signed({1'b0, cof2[mi3_pkg::DET_ADJ[k]][W:0]});
        phi[k] <= row2[k] * $signed(cof2[mi3_pkg::DET_ADJ[k]][CW-1:W+1]);
      end
      cof3 <= cof2;

      // recombine the partials
      for (int k = 0; k < 3; k++) begin
        term[k] <= ({{(DW-2*W){phi[k][2*W-1]}}, phi[k]} <<< (W + 1))
                 + {{(DW-2*W-2){plo[k][2*W+1]}}, plo[k]};
      end
      cof4 <= cof3;

      // sum the row expansion
      det <= term[0] + term[1] + term[2];
      adj <= cof4;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mi3_lane.sv
`default_nettype none

module mi3_lane #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [2*WORD_BITS:0] cof,
  input  wire logic signed [3*WORD_BITS+2:0] det,
  output logic [WORD_BITS-1:0]             value,
  output logic                             sat,
  output logic                             zero
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int CW  = 2 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int AW  = 2 * W;
  localparam int BW  = DW - 1;
  localparam int DDW = BW + 1;
  localparam int NA  = 2 * W + 2 * F + 1;
  localparam int UW  = ((NA > BW) ? NA : BW) + 1;
  localparam int QB  = W + 1;

  logic [AW-1:0]  absc;
  logic [BW-1:0]  absd;
  logic           neg1;
  logic           zero1;
  logic [UW-1:0]  num;
  logic [DDW-1:0] den;
  logic           neg2;
  logic           zero2;

  logic [UW-1:0]  rem  [0:QB];
  logic [DDW-1:0] dd   [0:QB];
  logic [QB-1:0]  q    [0:QB];
  logic           neg  [0:QB];
  logic           ovf  [0:QB];
  logic           zq   [0:QB];

  logic [UW-1:0]  shifted  [QB];
  logic [UW:0]    diff     [QB];
  logic           take     [QB];
  logic [UW-1:0]  low      [QB];
  logic [UW-1:0]  rem_next [QB];

  logic [CW-1:0]  cof_neg;
  logic [DW-1:0]  det_neg;
  logic [QB-1:0]  lim;
  logic           sat_c;
  logic [W-1:0]   mag;
  logic [W-1:0]   val;

  assign cof_neg = -cof;
  assign det_neg = -det;

  // One restoring step per stage, quotient bit QB-1-s at stage s
  always_comb begin
    for (int s = 0; s < QB; s++) begin
      shifted[s]  = rem[s] >> (QB - 1 - s);
      diff[s]     = {1'b0, shifted[s]} - {{(UW + 1 - DDW){1'b0}}, dd[s]};
      take[s]     = ~diff[s][UW];
      low[s]      = rem[s] & ~({UW{1'b1}} << (QB - 1 - s));
      rem_next[s] = take[s] ? ((diff[s][UW-1:0] << (QB - 1 - s)) | low[s]) : rem[s];
    end
  end

  // Clip to the word range and restore the sign
  always_comb begin
    lim   = neg[QB] ? (QB'(1) << (W - 1)) : ((QB'(1) << (W - 1)) - QB'(1));
    sat_c = ovf[QB] | (q[QB] > lim);
    mag   = sat_c ? lim[W-1:0] : q[QB][W-1:0];
    val   = neg[QB] ? (-mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // take magnitudes and the quotient sign
      absc  <= cof[CW-1] ? cof_neg[AW-1:0] : cof[AW-1:0];
      absd  <= det[DW-1] ? det_neg[BW-1:0] : det[BW-1:0];
      neg1  <= cof[CW-1] ^ det[DW-1];
      zero1 <= (det == '0);

      // build the rounding numerator and doubled divisor
      num   <= (UW'(absc) << (2 * F + 1)) + UW'(absd);
      den   <= {absd, 1'b0};
      neg2  <= neg1;
      zero2 <= zero1;

      // flag quotients that cannot fit the step count
      rem[0] <= num;
      dd[0]  <= den;
      q[0]   <= '0;
      neg[0] <= neg2;
      zq[0]  <= zero2;
      ovf[0] <= ((num >> QB) >= UW'(den));

      // advance the divider stages
      for (int s = 0; s < QB; s++) begin
        rem[s+1] <= rem_next[s];
        dd[s+1]  <= dd[s];
        q[s+1]   <= {q[s][QB-2:0], take[s]};
        neg[s+1] <= neg[s];
        ovf[s+1] <= ovf[s];
        zq[s+1]  <= zq[s];
      end

      value <= val;
      sat   <= sat_c;
      zero  <= zq[QB];
    end
  end

endmodule

`default_nettype wire

FILE: test/inverse_checker.sv
`timescale 1ns / 100ps

module inverse_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] b00, b01, b02, b10, b11, b12, b20, b21, b22,
  input  wire logic               singular,
  input  wire logic               saturated,
  output int                      errors,
  output int                      pending
);

  typedef logic signed [255:0] wide_t;
  typedef logic signed [31:0] elem_t;

  typedef struct {
    elem_t b [9];
    logic  singular;
    logic  saturated;
  } inverse_t;

  inverse_t inverse_q [$];

  // Exact adjugate over determinant, rounded half away from zero, clipped
  function automatic inverse_t invert_matrix(input elem_t m [9]);
    wide_t    x [9];
    wide_t    adj [9];
    wide_t    det, num, mag, dmag, quo, lim;
    logic     neg;
    inverse_t r;
    for (int i = 0; i < 9; i++) x[i] = m[i];
    adj[0] = x[4] * x[8] - x[5] * x[7];
    adj[1] = x[2] * x[7] - x[1] * x[8];
    adj[2] = x[1] * x[5] - x[2] * x[4];
    adj[3] = x[5] * x[6] - x[3] * x[8];
    adj[4] = x[0] * x[8] - x[2] * x[6];
    adj[5] = x[2] * x[3] - x[0] * x[5];
    adj[6] = x[3] * x[7] - x[4] * x[6];
    adj[7] = x[1] * x[6] - x[0] * x[7];
    adj[8] = x[0] * x[4] - x[1] * x[3];
    det = x[0] * adj[0] + x[1] * adj[3] + x[2] * adj[6];
    r.singular = (det == 0);
    r.saturated = 1'b0;
    for (int i = 0; i < 9; i++) r.b[i] = '0;
    if (det != 0) begin
      dmag = (det < 0) ? -det : det;
      for (int i = 0; i < 9; i++) begin
        num = adj[i] <<< 32;
        neg = (num < 0) != (det < 0);
        mag = (num < 0) ? -num : num;
        quo = (2 * mag + dmag) / (2 * dmag);
        lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7fff_ffff);
        if (quo > lim) begin
          quo = lim;
          r.saturated = 1'b1;
        end
        r.b[i] = neg ? elem_t'(-quo) : elem_t'(quo);
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Predict on each input transaction, compare on each output transaction
  always @(posedge clk) begin
    elem_t    m [9];
    elem_t    g [9];
    inverse_t want;
    if (!rst && in_valid && in_ready) begin
      m = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
      inverse_q.push_back(invert_matrix(m));
    end
    if (!rst && out_valid && out_ready) begin
      if (inverse_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = inverse_q.pop_front();
        g = '{b00, b01, b02, b10, b11, b12, b20, b21, b22};
        for (int i = 0; i < 9; i++)
          if (g[i] !== want.b[i])
            report($sformatf("b%0d%0d", i / 3, i % 3), g[i], want.b[i]);
        if (singular !== want.singular) report("singular", singular, want.singular);
        if (saturated !== want.saturated) report("saturated", saturated, want.saturated);
      end
    end
    pending <= inverse_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

FILE: test/matrix_inverse_3x3_top_tb.sv
`timescale 1ns / 100ps

module matrix_inverse_3x3_top_tb;

  typedef logic signed [31:0] elem_t;

  localparam elem_t ONE  = 32'sh0001_0000;
  localparam elem_t MAXV = 32'sh7fff_ffff;
  localparam elem_t MINV = 32'sh8000_0000;
  localparam int WATCH_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, singular, saturated;
  elem_t a [9];
  elem_t b [9];
  int errors, pending;
  int watch_cnt = 0;
  int sent = 0;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;
  logic stim_done = 1'b0;

  initial for (int i = 0; i < 9; i++) a[i] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix_inverse_3x3_top u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .a00(a[0]), .a01(a[1]), .a02(a[2]), .a10(a[3]), .a11(a[4]),
    .a12(a[5]), .a20(a[6]), .a21(a[7]), .a22(a[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .b00(b[0]), .b01(b[1]), .b02(b[2]), .b10(b[3]), .b11(b[4]),
    .b12(b[5]), .b20(b[6]), .b21(b[7]), .b22(b[8]),
    .singular(singular), .saturated(saturated)
  );

  inverse_checker u_check (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .a00(a[0]), .a01(a[1]), .a02(a[2]), .a10(a[3]), .a11(a[4]),
    .a12(a[5]), .a20(a[6]), .a21(a[7]), .a22(a[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .b00(b[0]), .b01(b[1]), .b02(b[2]), .b10(b[3]), .b11(b[4]),
    .b12(b[5]), .b20(b[6]), .b21(b[7]), .b22(b[8]),
    .singular(singular), .saturated(saturated),
    .errors(errors), .pending(pending)
  );

  // Offer one matrix after a random gap and hold it until the transaction
  task automatic send_matrix(input elem_t m [9]);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) a[i] <= m[i];
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  function automatic elem_t near(input int span);
    return elem_t'($urandom_range(0, 2 * span)) - elem_t'(span);
  endfunction

  // Mostly well-conditioned matrices, plus full-range, singular and tiny ones
  function automatic void random_matrix(output elem_t m [9]);
    int kind;
    int k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) m[i] = near(4 * 65536);
    case (kind)
      0, 1: begin
        for (int i = 0; i < 9; i++) m[i] = $urandom;
      end
      2: begin
        k = $urandom_range(0, 2);
        for (int j = 0; j < 3; j++) m[3 * ((k + 1) % 3) + j] = m[3 * k + j];
      end
      3: begin
        for (int i = 0; i < 9; i++) m[i] = near(16);
      end
      4: begin
        for (int i = 0; i < 9; i++) m[i] = near(2048);
        for (int i = 0; i < 3; i++) m[4 * i] = m[4 * i] + (($urandom & 1) ? ONE : -ONE);
      end
      default: begin
        for (int i = 0; i < 3; i++) m[4 * i] = m[4 * i] + 8 * ONE;
      end
    endcase
  endfunction

  // Receiver: random stalls, runs without stalls, and one long hold-off
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || stim_done)
      watch_cnt <= 0;
    else
      watch_cnt <= watch_cnt + 1;
    if (watch_cnt >= WATCH_LIMIT) begin
      $display("** matrix_inverse_3x3_top: FAILED **");
      $finish;
    end
  end

  initial begin
    elem_t m [9];
    elem_t dir [$][9];
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, signs, zero, singular, extremes, ties, saturation
    dir.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    dir.push_back('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
    dir.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    dir.push_back('{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                    7 * ONE, 8 * ONE, 9 * ONE});
    dir.push_back('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
    dir.push_back('{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV});
    dir.push_back('{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV});
    dir.push_back('{MAXV, MINV, 0, MINV, MAXV, 0, 0, 0, MINV});
    dir.push_back('{MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV});
    dir.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    dir.push_back('{-1, 0, 0, 0, 1, 0, 0, 0, -1});
    dir.push_back('{2 * ONE, 0, 0, 0, 4 * ONE, 0, 0, 0, 3 * ONE});
    dir.push_back('{3 * ONE, 0, 0, 0, -3 * ONE, 0, 0, 0, 7 * ONE});
    dir.push_back('{ONE, 2 * ONE, 0, 0, ONE, 3 * ONE, 4 * ONE, 0, ONE});
    dir.push_back('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0});
    dir.push_back('{2, 0, 0, 0, 2, 0, 0, 0, 2});
    dir.push_back('{32'sh0002_0000 + 1, 0, 0, 0, ONE, 0, 0, 0, ONE});
    dir.push_back('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    dir.push_back('{MAXV, 1, 0, 1, MAXV, 0, 0, 0, 1});
    dir.push_back('{ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE});
    foreach (dir[i]) begin
      m = dir[i];
      send_matrix(m);
    end

    // Random, with bursts without idling and one long output hold-off
    for (int n = 0; n < 1450; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == 700) begin
        no_idle = 1'b1;
        hold_req = 1'b1;
      end
      random_matrix(m);
      send_matrix(m);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then allow for the pipeline depth
    waited = 0;
    while ((pending != 0) && (waited < 20000)) begin
      @(posedge clk);
      waited++;
    end
    stim_done = 1'b1;
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0 && waited < 20000)
      $display("** matrix_inverse_3x3_top: PASSED **");
    else
      $display("** matrix_inverse_3x3_top: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_front.sv
rtl/core/mi3_lane.sv
rtl/core/matrix_inverse_3x3_top.sv
test/inverse_checker.sv
test/matrix_inverse_3x3_top_tb.sv
